// ===== hdl/event_flag_allocator_core_assert.svh =====
// Assertion macros shared by the allocator RTL
`ifndef EVENT_FLAG_ALLOCATOR_CORE_ASSERT_SVH
`define EVENT_FLAG_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define EFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define EFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/efa_pkg.sv =====
package efa_pkg;

  localparam int EVENT_WORDS    = 3;
  localparam int WAITER_ID_BITS = 8;
  localparam int WORD_BITS      = 64;
  localparam int BIT_IDX_W      = 6;
  localparam int EVENT_COUNT    = EVENT_WORDS * WORD_BITS;
  localparam int EV_IDX_W       = $clog2(EVENT_COUNT);
  localparam int WORD_IDX_W     = (EVENT_WORDS > 1) ? $clog2(EVENT_WORDS) : 1;

  localparam int OP_W     = 2;
  localparam int EVENT_W  = 8;
  localparam int WID_W    = 8;
  localparam int STATUS_W = 3;

  typedef logic [OP_W-1:0]           op_t;
  typedef logic [STATUS_W-1:0]       status_t;
  typedef logic [EV_IDX_W-1:0]       gidx_t;
  typedef logic [WORD_IDX_W-1:0]     word_idx_t;
  typedef logic [BIT_IDX_W-1:0]      bit_idx_t;
  typedef logic [WAITER_ID_BITS-1:0] waiter_t;

  localparam op_t OP_ALLOC = 2'd0;
  localparam op_t OP_SET   = 2'd1;
  localparam op_t OP_WAIT  = 2'd2;
  localparam op_t OP_CLEAR = 2'd3;

  localparam status_t ST_OK          = 3'd0;
  localparam status_t ST_EXHAUSTED   = 3'd1;
  localparam status_t ST_ALREADY_SET = 3'd2;
  localparam status_t ST_WAITER      = 3'd3;
  localparam status_t ST_BAD         = 3'd4;

  typedef struct packed {
    logic    we;
    gidx_t   addr;
    waiter_t data;
  } efa_ram_wr_t;

  function automatic word_idx_t word_of(gidx_t g);
    return word_idx_t'(g >> BIT_IDX_W);
  endfunction

  function automatic bit_idx_t bit_of(gidx_t g);
    return g[BIT_IDX_W-1:0];
  endfunction

  function automatic logic ev_in_range(logic [EVENT_W-1:0] ev);
    return (32'(ev) < 32'(EVENT_COUNT));
  endfunction

endpackage

// ===== hdl/efa_scan.sv =====
module efa_scan (
  input  logic [efa_pkg::WORD_BITS-1:0] free_word,
  output logic                          found,
  output efa_pkg::bit_idx_t             idx
);
  import efa_pkg::*;

  // lowest set bit wins
  always_comb begin
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_word[i]) begin
        idx = bit_idx_t'(i);
      end
    end
  end

  assign found = |free_word;

endmodule

// ===== hdl/efa_waiter_ram.sv =====
module efa_waiter_ram (
  input  logic                clk,
  input  efa_pkg::efa_ram_wr_t wr,
  input  efa_pkg::gidx_t      rd_addr,
  output efa_pkg::waiter_t    rd_data
);
  import efa_pkg::*;

  waiter_t mem [EVENT_COUNT];
  waiter_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/event_flag_allocator_core.sv =====
// channel | dir | tdata (low bit up)                    | tuser (low bit up)
// in_     | in  | event_index[7:0], waiter_id[15:8]     | operation[1:0]
// out_    | out | result_event[7:0], wake_id[15:8]      | status[2:0], wake[3]
//
// set, wait, clear: waiter RAM read at accept, result registered in S_EXEC.
// alloc: one 64-bit word per cycle through the shared priority encoder,
//   stopping at the first word with a free event or exhausted at the last.
// Next input taken once the result has transferred out.
// Reset clears all maps and waiter valid bits at once; no clearing pass.
module event_flag_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // event_index[7:0], waiter_id[15:8]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // result_event[7:0], wake_id[15:8]
  output logic [3:0]  out_tuser   // status[2:0], wake[3]
);
  import efa_pkg::*;
  `include "event_flag_allocator_core_assert.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]           state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic [EVENT_W-1:0]   ev_r, ev_nxt;
  waiter_t              who_r, who_nxt;
  word_idx_t            ptr_r, ptr_nxt;
  logic [WORD_BITS-1:0] alloc_map_r [EVENT_WORDS];
  logic [WORD_BITS-1:0] alloc_map_nxt [EVENT_WORDS];
  logic [WORD_BITS-1:0] raised_map_r [EVENT_WORDS];
  logic [WORD_BITS-1:0] raised_map_nxt [EVENT_WORDS];
  logic [EVENT_COUNT-1:0] wvalid_r, wvalid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [EVENT_W-1:0]   res_ev_r, res_ev_nxt;
  status_t              status_r, status_nxt;
  logic                 wake_r, wake_nxt;
  logic [WID_W-1:0]     wake_id_r, wake_id_nxt;

  logic        in_fire;
  logic        scan_found;
  bit_idx_t    scan_bit;
  efa_ram_wr_t ram_wr;
  waiter_t     ram_rdata;

  efa_scan u_scan (
    .free_word (~alloc_map_r[ptr_r]),
    .found     (scan_found),
    .idx       (scan_bit)
  );

  efa_waiter_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (gidx_t'(in_tdata[7:0])),
    .rd_data (ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {wake_id_r, res_ev_r};
  assign out_tuser  = {wake_r, status_r};

  always_comb begin
    gidx_t     g;
    word_idx_t w;
    bit_idx_t  b;
    state_nxt      = state_r;
    op_nxt         = op_r;
    ev_nxt         = ev_r;
    who_nxt        = who_r;
    ptr_nxt        = ptr_r;
    alloc_map_nxt  = alloc_map_r;
    raised_map_nxt = raised_map_r;
    wvalid_nxt     = wvalid_r;
    out_valid_nxt  = out_valid_r;
    res_ev_nxt     = res_ev_r;
    status_nxt     = status_r;
    wake_nxt       = wake_r;
    wake_id_nxt    = wake_id_r;
    ram_wr.we      = 1'b0;
    ram_wr.addr    = gidx_t'(ev_r);
    ram_wr.data    = who_r;
    g              = gidx_t'(ev_r);
    w              = word_of(g);
    b              = bit_of(g);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt    = in_tuser;
          ev_nxt    = in_tdata[7:0];
          who_nxt   = waiter_t'(in_tdata[15:8]);
          ptr_nxt   = '0;
          state_nxt = (in_tuser == OP_ALLOC) ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        g = gidx_t'({ptr_r, scan_bit});
        if (scan_found) begin
          alloc_map_nxt[ptr_r][scan_bit]  = 1'b1;
          raised_map_nxt[ptr_r][scan_bit] = 1'b0;
          wvalid_nxt[g]                   = 1'b0;
          res_ev_nxt    = EVENT_W'(g);
          status_nxt    = ST_OK;
          wake_nxt      = 1'b0;
          wake_id_nxt   = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (ptr_r == word_idx_t'(EVENT_WORDS - 1)) begin
          res_ev_nxt    = '0;
          status_nxt    = ST_EXHAUSTED;
          wake_nxt      = 1'b0;
          wake_id_nxt   = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_EXEC: begin
        res_ev_nxt    = ev_r;
        status_nxt    = ST_OK;
        wake_nxt      = 1'b0;
        wake_id_nxt   = '0;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (!ev_in_range(ev_r)) begin
          status_nxt = ST_BAD;
        end else begin
          case (op_r)
            OP_SET: begin
              raised_map_nxt[w][b] = 1'b1;
              if (wvalid_r[g]) begin
                wake_nxt    = 1'b1;
                wake_id_nxt = WID_W'(ram_rdata);
              end
            end
            OP_WAIT: begin
              if (raised_map_r[w][b]) begin
                status_nxt = ST_ALREADY_SET;
              end else begin
                ram_wr.we     = 1'b1;
                wvalid_nxt[g] = 1'b1;
                status_nxt    = ST_WAITER;
              end
            end
            OP_CLEAR: begin
              raised_map_nxt[w][b] = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      wvalid_r    <= '0;
      for (int i = 0; i < EVENT_WORDS; i++) begin
        alloc_map_r[i]  <= '0;
        raised_map_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      wvalid_r     <= wvalid_nxt;
      alloc_map_r  <= alloc_map_nxt;
      raised_map_r <= raised_map_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    ev_r      <= ev_nxt;
    who_r     <= who_nxt;
    ptr_r     <= ptr_nxt;
    res_ev_r  <= res_ev_nxt;
    status_r  <= status_nxt;
    wake_r    <= wake_nxt;
    wake_id_r <= wake_id_nxt;
  end

  `EFA_ASSERT_NXT(a_busy_after_accept, in_fire, state_r != S_IDLE, "idle after accept")
  `EFA_ASSERT_IMP(a_ptr_range, state_r == S_SCAN, ptr_r <= word_idx_t'(EVENT_WORDS - 1), "scan ptr out of range")
  `EFA_ASSERT_IMP(a_out_only_idle, out_valid_r, state_r == S_IDLE, "result pending while busy")
  `EFA_ASSERT_IMP(a_exhausted_zero, out_valid_r && status_r == ST_EXHAUSTED, res_ev_r == '0 && !wake_r, "exhausted result not zero")
  `EFA_ASSERT_IMP(a_wake_only_ok, out_valid_r && wake_r, status_r == ST_OK && op_r == OP_SET, "wake outside set")

endmodule
